@@ rtl/eert_pkg.sv @@
// package with sizes, types and state codes of the palindromic tree builder
`timescale 1ns / 1ps
package eert_pkg;
   localparam int MAX_LEN   = 4096;
   localparam int ALPHABET  = 26;
   localparam int NODE_CAP  = MAX_LEN + 2;
   localparam int NODE_W    = 13;
   localparam int POS_W     = 12;
   localparam int SYM_W     = 5;
   localparam int CHILD_D   = NODE_CAP * ALPHABET;
   localparam int CHILD_W   = 17;

   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic [NODE_W-1:0] length;
      logic              created;
      logic [NODE_W-1:0] parent;
      logic [NODE_W-1:0] link;
      logic              overflow;
   } res_type;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_WA   = 4'd1;
   localparam logic [3:0] ST_WB   = 4'd2;
   localparam logic [3:0] ST_WC   = 4'd3;
   localparam logic [3:0] ST_CA   = 4'd4;
   localparam logic [3:0] ST_CB   = 4'd5;
   localparam logic [3:0] ST_CC   = 4'd6;
   localparam logic [3:0] ST_FIN  = 4'd7;
   localparam logic [3:0] ST_DONE = 4'd8;
endpackage

@@ rtl/eert_ctrl.sv @@
// sequencer, node memories and shared suffix-link walk of the palindromic tree
`timescale 1ns / 1ps
module eert_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [eert_pkg::SYM_W-1:0]   in_sym,
   input  logic                         in_start,
   output logic                         res_valid,
   input  logic                         res_ready,
   output eert_pkg::res_type            res
);
   logic [3:0]                    state_ff, state_in;
   logic [eert_pkg::NODE_W-1:0]   pos_ff, pos_in, cur_ff, cur_in, ncnt_ff, ncnt_in;
   logic [eert_pkg::SYM_W-1:0]    sym_ff, sym_in;
   logic [eert_pkg::NODE_W-1:0]   n_ff, n_in, lnk_ff, lnk_in, wlen_ff, wlen_in;
   logic [eert_pkg::NODE_W-1:0]   x_ff, x_in, xlnk_ff, xlnk_in, newlen_ff, newlen_in;
   logic [eert_pkg::NODE_W-1:0]   key_ff, key_in, cand_ff, cand_in;
   logic                          phase_ff, phase_in, create_ff, create_in;
   eert_pkg::res_type             res_ff, res_in;

   logic [eert_pkg::SYM_W-1:0]    sym_mem [eert_pkg::MAX_LEN];
   logic [eert_pkg::NODE_W-1:0]   len_mem [eert_pkg::NODE_CAP];
   logic [eert_pkg::NODE_W-1:0]   link_mem [eert_pkg::NODE_CAP];
   logic [eert_pkg::NODE_W-1:0]   par_mem [eert_pkg::NODE_CAP];
   logic [eert_pkg::SYM_W-1:0]    nsym_mem [eert_pkg::NODE_CAP];
   logic [eert_pkg::NODE_W-1:0]   child_mem [eert_pkg::CHILD_D];

   logic [eert_pkg::SYM_W-1:0]    sym_rd, nsym_rd;
   logic [eert_pkg::NODE_W-1:0]   len_rd, link_rd, par_rd, child_rd;
   logic [eert_pkg::NODE_W-1:0]   node_addr, cur_len, cur_lnk;
   logic [eert_pkg::POS_W-1:0]    sym_addr;
   logic [eert_pkg::CHILD_W-1:0]  child_addr;
   logic [eert_pkg::NODE_W-1:0]   child_key;
   logic                          fin_we, cand_ok;

   // node memories are read at the walk node or at the child candidate just read, and at the new node in FIN
   always_comb begin
      case (state_ff)
         eert_pkg::ST_CB:  node_addr = child_rd;
         eert_pkg::ST_FIN: node_addr = ncnt_ff;
         default:          node_addr = n_ff;
      endcase
   end
   assign child_key  = (state_ff == eert_pkg::ST_FIN) ? x_ff : key_ff;
   assign child_addr = eert_pkg::CHILD_W'(child_key) * eert_pkg::CHILD_W'(eert_pkg::ALPHABET)
                       + eert_pkg::CHILD_W'(sym_ff);
   assign cur_len    = (n_ff == eert_pkg::NODE_W'(1)) ? '0 : len_rd;
   assign cur_lnk    = (n_ff < eert_pkg::NODE_W'(2)) ? '0 : link_rd;
   assign sym_addr   = eert_pkg::POS_W'(pos_ff - cur_len - eert_pkg::NODE_W'(1));
   assign fin_we     = (state_ff == eert_pkg::ST_FIN);
   // a table entry counts only if it names a node built so far that points back at this edge
   assign cand_ok    = (cand_ff >= eert_pkg::NODE_W'(2)) && (cand_ff < ncnt_ff) &&
                       (par_rd == key_ff) && (nsym_rd == sym_ff);

   always_ff @(posedge clock) begin
      if (fin_we) begin
         sym_mem[pos_ff[eert_pkg::POS_W-1:0]] <= sym_ff;
      end
      sym_rd <= sym_mem[sym_addr];
   end

   always_ff @(posedge clock) begin
      if (fin_we && create_ff) begin
         len_mem[node_addr]  <= newlen_ff;
         link_mem[node_addr] <= lnk_ff;
         par_mem[node_addr]  <= x_ff;
         nsym_mem[node_addr] <= sym_ff;
      end
      len_rd  <= len_mem[node_addr];
      link_rd <= link_mem[node_addr];
      par_rd  <= par_mem[node_addr];
      nsym_rd <= nsym_mem[node_addr];
   end

   always_ff @(posedge clock) begin
      if (fin_we && create_ff) begin
         child_mem[child_addr] <= ncnt_ff;
      end
      child_rd <= child_mem[child_addr];
   end

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      cur_in    = cur_ff;
      ncnt_in   = ncnt_ff;
      sym_in    = sym_ff;
      n_in      = n_ff;
      lnk_in    = lnk_ff;
      wlen_in   = wlen_ff;
      x_in      = x_ff;
      xlnk_in   = xlnk_ff;
      newlen_in = newlen_ff;
      key_in    = key_ff;
      cand_in   = cand_ff;
      phase_in  = phase_ff;
      create_in = create_ff;
      res_in    = res_ff;
      case (state_ff)
         eert_pkg::ST_IDLE: begin
            if (in_valid) begin
               sym_in    = in_sym;
               res_in    = '0;
               create_in = 1'b0;
               phase_in  = 1'b0;
               n_in      = cur_ff;
               if (in_start) begin
                  pos_in  = '0;
                  cur_in  = '0;
                  ncnt_in = eert_pkg::NODE_W'(2);
                  n_in    = '0;
               end
               if (in_sym >= eert_pkg::SYM_W'(eert_pkg::ALPHABET)) begin
                  state_in = eert_pkg::ST_DONE;
               end else if (!in_start && pos_ff >= eert_pkg::NODE_W'(eert_pkg::MAX_LEN)) begin
                  res_in.overflow = 1'b1;
                  state_in        = eert_pkg::ST_DONE;
               end else begin
                  state_in = eert_pkg::ST_WA;
               end
            end
         end
         eert_pkg::ST_WA: begin
            if (n_ff == '0) begin
               // length -1 root always wraps
               if (phase_ff) begin
                  key_in = '0;
               end else begin
                  x_in      = '0;
                  key_in    = '0;
                  newlen_in = eert_pkg::NODE_W'(1);
               end
               state_in = eert_pkg::ST_CA;
            end else begin
               state_in = eert_pkg::ST_WB;
            end
         end
         eert_pkg::ST_WB: begin
            lnk_in  = cur_lnk;
            wlen_in = cur_len;
            if (cur_len >= pos_ff) begin
               n_in     = cur_lnk;
               state_in = eert_pkg::ST_WA;
            end else begin
               state_in = eert_pkg::ST_WC;
            end
         end
         eert_pkg::ST_WC: begin
            if (sym_rd == sym_ff) begin
               key_in = n_ff;
               if (!phase_ff) begin
                  x_in      = n_ff;
                  xlnk_in   = lnk_ff;
                  newlen_in = wlen_ff + eert_pkg::NODE_W'(2);
               end
               state_in = eert_pkg::ST_CA;
            end else begin
               n_in     = lnk_ff;
               state_in = eert_pkg::ST_WA;
            end
         end
         eert_pkg::ST_CA: begin
            state_in = eert_pkg::ST_CB;
         end
         eert_pkg::ST_CB: begin
            cand_in  = child_rd;
            state_in = eert_pkg::ST_CC;
         end
         eert_pkg::ST_CC: begin
            if (phase_ff) begin
               if (cand_ok) begin
                  lnk_in = cand_ff;
               end else begin
                  lnk_in = eert_pkg::NODE_W'(1);
               end
               create_in = 1'b1;
               state_in  = eert_pkg::ST_FIN;
            end else if (cand_ok) begin
               res_in.node   = cand_ff;
               res_in.length = len_rd;
               state_in      = eert_pkg::ST_FIN;
            end else if (ncnt_ff < eert_pkg::NODE_W'(eert_pkg::NODE_CAP)) begin
               if (x_ff == '0) begin
                  lnk_in    = eert_pkg::NODE_W'(1);
                  create_in = 1'b1;
                  state_in  = eert_pkg::ST_FIN;
               end else begin
                  phase_in = 1'b1;
                  n_in     = xlnk_ff;
                  state_in = eert_pkg::ST_WA;
               end
            end else begin
               res_in.node   = eert_pkg::NODE_W'(1);
               res_in.length = '0;
               state_in      = eert_pkg::ST_FIN;
            end
         end
         eert_pkg::ST_FIN: begin
            pos_in = pos_ff + eert_pkg::NODE_W'(1);
            if (create_ff) begin
               res_in.node    = ncnt_ff;
               res_in.length  = newlen_ff;
               res_in.created = 1'b1;
               res_in.parent  = x_ff;
               res_in.link    = lnk_ff;
               cur_in         = ncnt_ff;
               ncnt_in        = ncnt_ff + eert_pkg::NODE_W'(1);
            end else begin
               cur_in = res_ff.node;
            end
            state_in = eert_pkg::ST_DONE;
         end
         eert_pkg::ST_DONE: begin
            if (res_ready) begin
               state_in = eert_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = eert_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= eert_pkg::ST_IDLE;
         pos_ff   <= '0;
         cur_ff   <= '0;
         ncnt_ff  <= eert_pkg::NODE_W'(2);
         phase_ff <= 1'b0;
         create_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         cur_ff    <= cur_in;
         ncnt_ff   <= ncnt_in;
         phase_ff  <= phase_in;
         create_ff <= create_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff    <= sym_in;
      n_ff      <= n_in;
      lnk_ff    <= lnk_in;
      wlen_ff   <= wlen_in;
      x_ff      <= x_in;
      xlnk_ff   <= xlnk_in;
      newlen_ff <= newlen_in;
      key_ff    <= key_in;
      cand_ff   <= cand_in;
      res_ff    <= res_in;
   end

   assign in_ready  = (state_ff == eert_pkg::ST_IDLE);
   assign res_valid = (state_ff == eert_pkg::ST_DONE);
   assign res       = res_ff;
endmodule

@@ rtl/palindromic_tree_builder_top.sv @@
// top level of the palindromic tree builder with the response output register
`timescale 1ns / 1ps
// Builds a palindromic tree one symbol per request and answers each request with one
// response. A request passes through a suffix walk, in which each node passed over is
// tested in states WA, WB and WC (WA and WB alone when the node is too long to be
// wrapped, WA alone at the length -1 root), then a child lookup in CA, CB and CC, and
// then FIN and DONE. A new node whose parent is not the length -1 root adds a second
// walk and child lookup for its link, with the same states per node passed over.
// The walk costs one node memory read and one symbol memory read per node visited.
// The block takes no request until the previous one has been handed to the response
// register. The child table needs no clearing pass: an entry is trusted only when the
// node it names records this parent and symbol, so a start flag takes effect at once.
module palindromic_tree_builder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // symbol[4:0], zero fill
   input  logic        req_tuser,   // start_new
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // suffix_node, suffix_length, created_parent, created_link
   output logic [1:0]  rsp_tuser    // node_created, overflow
);
   logic              res_valid, res_ready;
   eert_pkg::res_type res;
   logic              out_valid_ff, out_valid_in;
   logic [55:0]       out_data_ff, out_data_in;
   logic [1:0]        out_user_ff, out_user_in;

   eert_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_sym    (req_tdata[4:0]),
      .in_start  (req_tuser),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   assign res_ready = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_user_in  = out_user_ff;
      if (res_valid && res_ready) begin
         out_valid_in = 1'b1;
         out_data_in  = {4'b0, res.link, res.parent, res.length, res.node};
         out_user_in  = {res.overflow, res.created};
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      out_user_ff <= out_user_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
endmodule

@@ rtl/eert_check.sv @@
// port checker of the palindromic tree builder and its bind
`timescale 1ns / 1ps
module eert_check (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");
   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == 56'd0 && !rsp_tuser[0])
      else $error("overflow response carries data");
   a_nocreate: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[51:26] == 26'd0)
      else $error("parent or link set without a new node");
endmodule

bind palindromic_tree_builder_top eert_check u_eert_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ tb/tb_palindromic_tree_builder_top.sv @@
// self-checking testbench for the palindromic tree builder with a built-in tree predictor
`timescale 1ns / 1ps
module tb_palindromic_tree_builder_top;

   localparam int CYCLE_LIMIT = 3000000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // symbol[4:0], zero fill
   logic        req_tuser;   // start_new
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;   // suffix_node, suffix_length, created_parent, created_link
   logic [1:0]  rsp_tuser;   // node_created, overflow

   palindromic_tree_builder_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // predicted tree
   int       tree_len  [eert_pkg::NODE_CAP];
   int       tree_link [eert_pkg::NODE_CAP];
   int       tree_kid  [eert_pkg::CHILD_D];
   bit [4:0] text_syms [eert_pkg::MAX_LEN];
   int       kids_used [$];
   int       text_pos;
   int       tail_node;
   int       node_total;

   eert_pkg::res_type expected_rsps [$];
   int       errors = 0;
   int       cycles = 0;
   bit       idle_on;
   bit       hold_go;
   bit       hold_done;
   int       hold_left;

   initial begin
      clock = 1'b0;
   end
   always #6 clock = ~clock;

   task automatic clear_tree();
      foreach (kids_used[i]) tree_kid[kids_used[i]] = 0;
      kids_used.delete();
      tree_len[0]  = -1;
      tree_len[1]  = 0;
      tree_link[0] = 0;
      tree_link[1] = 0;
      text_pos     = 0;
      tail_node    = 0;
      node_total   = 2;
   endtask

   function automatic bit cannot_wrap(int n, int pos, int c);
      int len;
      if (n == 0) return 1'b0;
      len = tree_len[n];
      if (len < 0 || len >= pos) return 1'b1;
      return text_syms[pos - len - 1] != c;
   endfunction

   function automatic int follow_links(int n, int pos, int c);
      int steps;
      steps = 0;
      while (steps < eert_pkg::NODE_CAP && cannot_wrap(n, pos, c)) begin
         n = tree_link[n];
         steps++;
      end
      if (steps >= eert_pkg::NODE_CAP) n = 0;
      return n;
   endfunction

   task automatic add_symbol(input int c, input bit start, output eert_pkg::res_type r);
      int x, kid, v, vc, nn;
      r = '0;
      if (start) clear_tree();
      if (c >= eert_pkg::ALPHABET) return;
      if (text_pos >= eert_pkg::MAX_LEN) begin
         r.overflow = 1'b1;
         return;
      end
      x   = follow_links(tail_node, text_pos, c);
      kid = tree_kid[x * eert_pkg::ALPHABET + c];
      if (kid == 0 && node_total < eert_pkg::NODE_CAP) begin
         nn = node_total++;
         tree_len[nn] = tree_len[x] + 2;
         v = 0;
         if (x != 0) v = follow_links(tree_link[x], text_pos, c);
         vc = tree_kid[v * eert_pkg::ALPHABET + c];
         tree_link[nn] = (x == 0 || vc == 0) ? 1 : vc;
         tree_kid[x * eert_pkg::ALPHABET + c] = nn;
         kids_used.insert(kids_used.size(), x * eert_pkg::ALPHABET + c);
         kid       = nn;
         r.created = 1'b1;
         r.parent  = x[eert_pkg::NODE_W-1:0];
         r.link    = tree_link[nn][eert_pkg::NODE_W-1:0];
      end
      if (kid == 0) kid = 1;
      text_syms[text_pos] = c[4:0];
      text_pos++;
      tail_node = kid;
      r.node    = kid[eert_pkg::NODE_W-1:0];
      r.length  = (tree_len[kid] < 0) ? '0 : tree_len[kid][eert_pkg::NODE_W-1:0];
   endtask

   task automatic send_symbol(input int c, input bit start);
      eert_pkg::res_type r;
      if (idle_on && $urandom_range(99) < 32) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, c[4:0]};
      req_tuser  <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      add_symbol(c, start, r);
      expected_rsps.insert(expected_rsps.size(), r);
   endtask

   task automatic report_mismatch(string field, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
      errors++;
   endtask

   // response checker
   always @(posedge clock) begin
      eert_pkg::res_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected response node", int'(rsp_tdata[12:0]), 0);
         end else begin
            w = expected_rsps.pop_front();
            if (rsp_tdata[12:0] !== w.node)
               report_mismatch("node", int'(rsp_tdata[12:0]), int'(w.node));
            if (rsp_tdata[25:13] !== w.length)
               report_mismatch("length", int'(rsp_tdata[25:13]), int'(w.length));
            if (rsp_tdata[38:26] !== w.parent)
               report_mismatch("parent", int'(rsp_tdata[38:26]), int'(w.parent));
            if (rsp_tdata[51:39] !== w.link)
               report_mismatch("link", int'(rsp_tdata[51:39]), int'(w.link));
            if (rsp_tdata[55:52] !== 4'b0)
               report_mismatch("fill", int'(rsp_tdata[55:52]), 0);
            if (rsp_tuser[0] !== w.created)
               report_mismatch("created", int'(rsp_tuser[0]), int'(w.created));
            if (rsp_tuser[1] !== w.overflow)
               report_mismatch("overflow", int'(rsp_tuser[1]), int'(w.overflow));
         end
      end
   end

   // receiver with random stalls and one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  = 0;
         hold_done  = 1'b0;
      end else begin
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !idle_on || ($urandom_range(99) >= 32);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL palindromic_tree_builder_top");
         $finish;
      end
   end

   task automatic test_directed();
      send_symbol(0, 1'b1);
      send_symbol(0, 1'b0);
      send_symbol(0, 1'b0);
      send_symbol(1, 1'b0);
      send_symbol(0, 1'b0);
      send_symbol(0, 1'b0);
      send_symbol(1, 1'b0);
      send_symbol(25, 1'b0);
      send_symbol(26, 1'b0);
      send_symbol(31, 1'b0);
      send_symbol(25, 1'b0);
      send_symbol(1, 1'b0);
      send_symbol(31, 1'b1);    // out-of-range symbol still clears
      send_symbol(2, 1'b0);
      send_symbol(30, 1'b1);
      send_symbol(25, 1'b1);
      send_symbol(24, 1'b0);
      send_symbol(25, 1'b0);
      send_symbol(24, 1'b0);
      send_symbol(25, 1'b0);
   endtask

   task automatic test_backpressure();
      hold_go = 1'b1;
      for (int i = 0; i < 20; i++) send_symbol($urandom_range(0, 1), i == 0);
   endtask

   task automatic test_random();
      int sent, run_len, width, base, c;
      sent = 0;
      while (sent < 1240) begin
         idle_on = !(sent >= 500 && sent < 800);
         run_len = $urandom_range(1, 40);
         width   = $urandom_range(1, 4);
         base    = $urandom_range(0, eert_pkg::ALPHABET - width);
         for (int i = 0; i < run_len; i++) begin
            c = base + $urandom_range(0, width - 1);
            if ($urandom_range(99) < 4) c = $urandom_range(eert_pkg::ALPHABET, 31);
            send_symbol(c, i == 0 || $urandom_range(199) == 0);
            if (c < eert_pkg::ALPHABET) sent++;
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin
      idle_on    = 1'b1;
      hold_go    = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      clear_tree();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random();
      req_tvalid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("PASS palindromic_tree_builder_top");
      end else begin
         $display("FAIL palindromic_tree_builder_top");
      end
      $finish;
   end
endmodule
